/* rtl/dset_pkg.sv */
// Shared types and constants for the duplicate-free id set.
package dset_pkg;

  // Fixed field widths of the request and result channels
  localparam int unsigned OP_W        = 2;
  localparam int unsigned IDX_FIELD_W = 10;
  localparam int unsigned CAP_W       = 11;
  localparam int unsigned CNT_OUT_W   = 11;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = CAP_W;

  localparam logic [CAP_W-1:0] CAPACITY_RST = 11'd1024;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_QUERY  = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SORTED_MODE = 1'd0,
    REG_CAPACITY    = 1'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SRCH = 2'd1,
    ST_FIN  = 2'd2
  } state_e;

  // Broadcast commands to the cell row
  typedef struct packed {
    logic shift;     // sorted insert: open a slot at pos and write the id
    logic set_bit;   // bitmap insert: set presence bit of the id
    logic clr_bits;  // clear: drop every presence bit
  } cell_ctrl_t;

  // Per-cell compare result against the broadcast id
  typedef struct packed {
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

/* rtl/dset_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dset_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/dset_cell.sv */
// One cell of the set row: a sorted-order slot, a presence bit and compare flags.
module dset_cell #(
  parameter int unsigned ID_BITS = 16,
  parameter int unsigned IW      = 10,
  parameter int unsigned CW      = 11,
  parameter int unsigned IDX     = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  dset_pkg::cell_ctrl_t  ctrl_i,
  input  logic [CW-1:0]         pos_i,       // insert position
  input  logic [CW-1:0]         cnt_i,       // entries before the insert
  input  logic [ID_BITS-1:0]    id_i,        // id under test / to insert
  input  logic [IW-1:0]         set_idx_i,   // bitmap slot to mark
  input  logic [ID_BITS-1:0]    prev_val_i,  // value of the cell below
  output logic [ID_BITS-1:0]    val_o,
  output dset_pkg::cell_flags_t flags_o,
  output logic                  pbit_o
);
  import dset_pkg::*;

  localparam logic [CW:0]   MY_POS = (CW+1)'(IDX);
  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic [ID_BITS-1:0] val_q, val_d;
  cell_flags_t        flags_q, flags_d;
  logic               pbit_q, pbit_d;
  logic               take_prev, take_id;

  // Shift up by one for slots in (pos, cnt], drop the id into slot pos
  assign take_prev = ctrl_i.shift && (MY_POS > {1'b0, pos_i}) && (MY_POS <= {1'b0, cnt_i});
  assign take_id   = ctrl_i.shift && (MY_POS == {1'b0, pos_i});

  always_comb begin
    val_d = val_q;
    if (take_id) begin
      val_d = id_i;
    end else if (take_prev) begin
      val_d = prev_val_i;
    end
    flags_d.lt = (val_q < id_i);
    flags_d.eq = (val_q == id_i);
    pbit_d = pbit_q;
    if (ctrl_i.clr_bits) begin
      pbit_d = 1'b0;
    end else if (ctrl_i.set_bit && (set_idx_i == MY_IDX)) begin
      pbit_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q   <= val_d;
    flags_q <= flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pbit_q <= 1'b0;
    end else begin
      pbit_q <= pbit_d;
    end
  end

  assign val_o   = val_q;
  assign flags_o = flags_q;
  assign pbit_o  = pbit_q;

endmodule

/* rtl/dedup_id_set_insert_query_unit.sv */
// Top level of the duplicate-free id set: cell row, order memory and control.
//
// Channel   | Dir | Handshake        | Payload
// ----------+-----+------------------+---------------------------------------------
// s_axis    | in  | tvalid / tready  | tuser: mode; tdata: item_id, entry_index
// m_axis    | out | tvalid / tready  | tdata: added, present, full_res, rejected,
//           |     |                  |        entry_id, entry_count
// cfg       | in  | cfg_we_i only    | cfg_idx_i selects, cfg_data_i written
//
// Flow: bitmap insert/query, clear and read go from the idle state straight to the
//   final state, which loads the result register. Sorted insert/query first runs a
//   binary search over the cell flags, one probe per cycle.
// A new request is taken only in the idle state; the output register lets a
//   finished result wait while the next request comes in.
// The final cycle stalls while the output register holds an untaken result.
// Reset clears count and every presence bit at once; no clearing pass. The
//   order memory and sorted cells start undefined.
module dedup_id_set_insert_query_unit #(
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned ID_BITS     = 16,
  localparam int unsigned IN_W  = ((ID_BITS + dset_pkg::IDX_FIELD_W + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((ID_BITS + dset_pkg::CNT_OUT_W + 4 + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // request stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [IN_W-1:0]                 s_axis_tdata,  // item_id, entry_index
  input  logic [dset_pkg::OP_W-1:0]       s_axis_tuser,  // mode
  // result stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // added, present, full_res, rejected, entry_id, entry_count
  output logic [OUT_W-1:0]                m_axis_tdata,
  // configuration
  input  logic                            cfg_we_i,
  input  logic [dset_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dset_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import dset_pkg::*;

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  // ---------------- configuration registers ----------------
  logic             sorted_mode_q;
  logic [CAP_W-1:0] capacity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_mode_q <= 1'b0;
      capacity_q    <= CAPACITY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SORTED_MODE: sorted_mode_q <= cfg_data_i[0];
        REG_CAPACITY:    capacity_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Capacity saturates at the row length
  logic [CW+CAP_W-1:0] cap_w, cap_lim_w, cap_sat_w;
  logic [CW-1:0]       cap_eff;
  assign cap_w     = {{CW{1'b0}}, capacity_q};
  assign cap_lim_w = (CW+CAP_W)'(MAX_ENTRIES);
  assign cap_sat_w = (cap_w > cap_lim_w) ? cap_lim_w : cap_w;
  assign cap_eff   = cap_sat_w[CW-1:0];

  // ---------------- request fields ----------------
  op_e                    in_op;
  logic [ID_BITS-1:0]     in_id;
  logic [IDX_FIELD_W-1:0] in_idx;
  logic                   in_acc;

  assign in_op  = op_e'(s_axis_tuser);
  assign in_id  = s_axis_tdata[ID_BITS-1:0];
  assign in_idx = s_axis_tdata[ID_BITS +: IDX_FIELD_W];
  assign in_acc = s_axis_tvalid && s_axis_tready;

  op_e                    req_op_q;
  logic [ID_BITS-1:0]     req_id_q;
  logic [IDX_FIELD_W-1:0] req_idx_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_op_q  <= in_op;
      req_id_q  <= in_id;
      req_idx_q <= in_idx;
    end
  end

  // ---------------- control state ----------------
  state_e        state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic          found_q, found_d;
  logic          out_valid_q, out_valid_d;
  logic          in_ready, fire;

  // ---------------- cell row ----------------
  cell_ctrl_t         cell_ctrl;
  logic [ID_BITS-1:0] cmp_id;
  logic [ID_BITS-1:0] cell_val [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] lt_vec, eq_vec, pres_vec;
  logic [ID_BITS+IW-1:0]  id_ext;
  logic [IW-1:0]          id_slot;

  // The row compares against the incoming id at accept so flags are ready next cycle
  assign cmp_id  = (state_q == ST_IDLE) ? in_id : req_id_q;
  assign id_ext  = {{IW{1'b0}}, req_id_q};
  assign id_slot = id_ext[IW-1:0];

  for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
    logic [ID_BITS-1:0] prev_val;
    cell_flags_t        flags;
    if (gi == 0) begin : g_head
      assign prev_val = '0;
    end else begin : g_link
      assign prev_val = cell_val[gi-1];
    end
    dset_cell #(
      .ID_BITS (ID_BITS),
      .IW      (IW),
      .CW      (CW),
      .IDX     (gi)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cell_ctrl),
      .pos_i      (lo_q),
      .cnt_i      (count_q),
      .id_i       (cmp_id),
      .set_idx_i  (id_slot),
      .prev_val_i (prev_val),
      .val_o      (cell_val[gi]),
      .flags_o    (flags),
      .pbit_o     (pres_vec[gi])
    );
    assign lt_vec[gi] = flags.lt;
    assign eq_vec[gi] = flags.eq;
  end

  // ---------------- insertion-order memory ----------------
  logic                   ram_we;
  logic [IW-1:0]          ram_waddr, ram_raddr;
  logic [ID_BITS-1:0]     ram_rdata;
  logic [IW+IDX_FIELD_W-1:0] in_idx_ext;

  assign in_idx_ext = {{IW{1'b0}}, in_idx};
  assign ram_raddr  = in_idx_ext[IW-1:0];
  assign ram_waddr  = count_q[IW-1:0];

  dset_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_id_q),
    .re_i    (in_acc),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // ---------------- binary search step ----------------
  logic [CW:0]   mid_sum, mid_w;
  logic [IW-1:0] mid;
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_w   = mid_sum >> 1;
  assign mid     = mid_w[IW-1:0];

  always_comb begin
    state_d  = state_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    found_d  = found_q;
    in_ready = 1'b0;
    fire     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (s_axis_tvalid) begin
          lo_d    = '0;
          hi_d    = count_q;
          found_d = 1'b0;
          if (sorted_mode_q && (in_op == OP_INSERT || in_op == OP_QUERY)) begin
            state_d = ST_SRCH;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_SRCH: begin
        if (lo_q < hi_q) begin
          if (eq_vec[mid]) begin
            found_d = 1'b1;
            lo_d    = mid_w[CW-1:0];
            state_d = ST_FIN;
          end else if (lt_vec[mid]) begin
            lo_d = mid_w[CW-1:0] + CW'(1);
          end else begin
            hi_d = mid_w[CW-1:0];
          end
        end else begin
          // lo is the insert position
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          fire    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    found_q <= found_d;
  end

  // ---------------- result and commit ----------------
  logic                r_added, r_present, r_full, r_rej;
  logic [ID_BITS-1:0]  r_eid;
  logic [CW-1:0]       cnt_next;
  logic                at_cap, id_out_of_range, idx_out_of_range;
  logic [ID_BITS+CW-1:0]     rng_id_w, rng_cap_w;
  logic [CW+IDX_FIELD_W-1:0] rd_idx_w, rd_cnt_w;
  logic [CW+CNT_OUT_W-1:0]   cnt_out_ext;
  logic [OUT_W-1:0]          out_data_q, out_data_d;

  assign at_cap           = (count_q >= cap_eff);
  assign rng_id_w         = {{CW{1'b0}}, req_id_q};
  assign rng_cap_w        = {{ID_BITS{1'b0}}, cap_eff};
  assign id_out_of_range  = (rng_id_w >= rng_cap_w);
  assign rd_idx_w         = {{CW{1'b0}}, req_idx_q};
  assign rd_cnt_w         = {{IDX_FIELD_W{1'b0}}, count_q};
  assign idx_out_of_range = (rd_idx_w >= rd_cnt_w);

  always_comb begin
    r_added   = 1'b0;
    r_present = 1'b0;
    r_full    = 1'b0;
    r_rej     = 1'b0;
    r_eid     = '0;
    cnt_next  = count_q;
    unique case (req_op_q) inside
      OP_INSERT, OP_QUERY: begin
        if (sorted_mode_q) begin
          if (found_q) begin
            r_present = 1'b1;
          end else if (req_op_q == OP_INSERT) begin
            if (at_cap) r_full = 1'b1;
            else        r_added = 1'b1;
          end
        end else begin
          // range check, then membership, then full
          if (id_out_of_range) begin
            r_rej = 1'b1;
          end else if (pres_vec[id_slot]) begin
            r_present = 1'b1;
          end else if (req_op_q == OP_INSERT) begin
            if (at_cap) r_full = 1'b1;
            else        r_added = 1'b1;
          end
        end
        if (r_added) begin
          cnt_next = count_q + CW'(1);
        end
      end
      OP_CLEAR: begin
        cnt_next = '0;
      end
      OP_READ: begin
        if (idx_out_of_range) r_rej = 1'b1;
        else                  r_eid = ram_rdata;
      end
      default: ;
    endcase
  end

  // Every set presence bit belongs to a listed id, so clear drops them all
  assign cell_ctrl.shift    = fire && r_added && sorted_mode_q;
  assign cell_ctrl.set_bit  = fire && r_added && !sorted_mode_q;
  assign cell_ctrl.clr_bits = fire && (req_op_q == OP_CLEAR);
  assign ram_we             = fire && r_added;

  assign count_d     = fire ? cnt_next : count_q;
  assign cnt_out_ext = {{CNT_OUT_W{1'b0}}, cnt_next};
  assign out_data_d  = OUT_W'({cnt_out_ext[CNT_OUT_W-1:0], r_eid, r_rej, r_full,
                               r_present, r_added});
  assign out_valid_d = fire ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign s_axis_tready = in_ready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* dv/tb.sv */
// Self-checking testbench for the duplicate-free id set unit.
`timescale 1ns / 1ps

module tb;
  import dset_pkg::*;

  localparam int unsigned SET_DEPTH  = 1024;
  localparam int unsigned FILL_N     = 100;   // sorted set size for the back-to-back fill
  localparam int unsigned QUIET_MAX  = 4000;  // cycles without any handshake
  localparam int unsigned DRAIN_WAIT = 16;    // margin for the longest sorted search
  localparam int unsigned SHOW_MAX   = 10;

  // Result word fields, last member in the lowest bits
  typedef struct packed {
    logic [10:0] entry_count;
    logic [15:0] entry_id;
    logic        rejected;
    logic        full_res;
    logic        present;
    logic        added;
  } set_result_t;

  // Own copy of the set state; predicts one result per accepted request
  class set_scoreboard;
    bit          sorted_on;
    logic [10:0] cap_reg;
    logic [15:0] arrival_ids[SET_DEPTH];  // insertion order
    logic [15:0] ranked_ids[SET_DEPTH];   // ascending copy for sorted mode
    bit          seen_bits[SET_DEPTH];    // presence bits for bitmap mode
    int          held;
    set_result_t owed_results[$];
    int unsigned bad_count, checked_count;
    int unsigned n_added, n_present, n_full, n_rejected;

    function new();
      sorted_on = 1'b0;
      cap_reg   = CAPACITY_RST;
      held      = 0;
      foreach (arrival_ids[i]) begin
        arrival_ids[i] = '0;
        ranked_ids[i]  = '0;
        seen_bits[i]   = 1'b0;
      end
    endfunction

    function void set_reg(cfg_reg_e r, logic [10:0] v);
      case (r)
        REG_SORTED_MODE: sorted_on = v[0];
        default:         cap_reg = v;
      endcase
    endfunction

    // Binary search over ranked_ids[0..held); pos is the hit or the insert slot
    function bit find_ranked(logic [15:0] id, output int pos);
      int lo, hi, mid;
      lo = 0;
      hi = held;
      while (lo < hi) begin
        mid = (lo + hi) / 2;
        if (ranked_ids[mid] == id) begin
          pos = mid;
          return 1'b1;
        end
        if (ranked_ids[mid] < id) lo = mid + 1;
        else hi = mid;
      end
      pos = lo;
      return 1'b0;
    endfunction

    function void note_request(op_e op, logic [15:0] id, logic [9:0] idx);
      set_result_t res;
      int lim, pos;
      bit hit;
      res = '0;
      lim = (cap_reg > SET_DEPTH) ? SET_DEPTH : int'(cap_reg);
      case (op) inside
        OP_INSERT, OP_QUERY: begin
          if (sorted_on) begin
            hit = find_ranked(id, pos);
            if (hit) begin
              res.present = 1'b1;
            end else if (op == OP_INSERT) begin
              if (held >= lim) begin
                res.full_res = 1'b1;
              end else begin
                for (int i = held; i > pos; i--) ranked_ids[i] = ranked_ids[i-1];
                ranked_ids[pos]   = id;
                arrival_ids[held] = id;
                held++;
                res.added = 1'b1;
              end
            end
          end else if (id >= lim) begin
            res.rejected = 1'b1;
          end else if (seen_bits[id]) begin
            res.present = 1'b1;
          end else if (op == OP_INSERT) begin
            if (held >= lim) begin
              res.full_res = 1'b1;
            end else begin
              seen_bits[id]     = 1'b1;
              arrival_ids[held] = id;
              held++;
              res.added = 1'b1;
            end
          end
        end
        OP_CLEAR: begin
          // drops only the bits of listed ids, whatever the mode
          for (int i = 0; i < held; i++)
            if (arrival_ids[i] < SET_DEPTH) seen_bits[arrival_ids[i]] = 1'b0;
          held = 0;
        end
        default: begin
          if (idx >= held) res.rejected = 1'b1;
          else res.entry_id = arrival_ids[idx];
        end
      endcase
      res.entry_count = 11'(held);
      n_added    += res.added;
      n_present  += res.present;
      n_full     += res.full_res;
      n_rejected += res.rejected;
      owed_results = {owed_results, res};
    endfunction

    function void check_result(logic [31:0] word);
      set_result_t got, want;
      string diffs;
      got = word[30:0];
      checked_count++;
      if (owed_results.size() == 0) begin
        bad_count++;
        if (bad_count <= SHOW_MAX)
          $display("%0t: result %h arrived with no request pending", $realtime, word);
        return;
      end
      want  = owed_results.pop_front();
      diffs = "";
      if (got.added !== want.added)             diffs = {diffs, " added"};
      if (got.present !== want.present)         diffs = {diffs, " present"};
      if (got.full_res !== want.full_res)       diffs = {diffs, " full_res"};
      if (got.rejected !== want.rejected)       diffs = {diffs, " rejected"};
      if (got.entry_id !== want.entry_id)       diffs = {diffs, " entry_id"};
      if (got.entry_count !== want.entry_count) diffs = {diffs, " entry_count"};
      if (word[31] !== 1'b0)                    diffs = {diffs, " padding"};
      if (diffs != "") begin
        bad_count++;
        if (bad_count <= SHOW_MAX)
          $display("%0t: mismatch in%s: exp add=%b pre=%b full=%b rej=%b id=%0d cnt=%0d",
                   $realtime, diffs, want.added, want.present, want.full_res,
                   want.rejected, want.entry_id, want.entry_count,
                   "\n    got add=%b pre=%b full=%b rej=%b id=%0d cnt=%0d pad=%b",
                   got.added, got.present, got.full_res, got.rejected,
                   got.entry_id, got.entry_count, word[31]);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // request side
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [31:0]           s_axis_tdata = '0;  // [15:0] item_id, [25:16] entry_index
  logic [OP_W-1:0]       s_axis_tuser = '0;  // [1:0] mode
  // result side
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [0] added, [1] present, [2] full_res, [3] rejected, [19:4] entry_id,
  // [30:20] entry_count
  logic [31:0]           m_axis_tdata;
  // configuration
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  set_scoreboard board = new();

  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  logic [15:0] pool_base = '0;     // sorted-mode ids cluster here to force repeats
  int unsigned op_tally[4];
  int unsigned settings_used;
  int unsigned quiet_cycles;

  dedup_id_set_insert_query_unit #(
    .MAX_ENTRIES(SET_DEPTH),
    .ID_BITS    (16)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial forever #10 clk_i = ~clk_i;

  // Watchdog: give up when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_MAX) begin
      $display("%0t: no handshake for %0d cycles", $realtime, QUIET_MAX);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result sink: random back-pressure drawn per result, every result checked
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = sink_idle_on ? $urandom_range(0, 18) : 0;
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.check_result(m_axis_tdata);
    end
  end

  // Issue one request; valid stays high afterward unless the next gap lowers it
  task automatic send_request(op_e op, logic [15:0] id, logic [9:0] idx);
    int unsigned gap;
    gap = src_idle_on ? $urandom_range(0, 18) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'd0, idx, id};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_request(op, id, idx);
    op_tally[int'(op)]++;
  endtask

  // Quiesce: stop requests, wait for every result, then cover the search latency
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (board.owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Write both registers with the block idle. Going from bitmap to sorted
  // needs an empty set, since the sorted copy was never built.
  task automatic enter_settings(bit sorted, logic [10:0] cap);
    logic [10:0] mode_word;
    settle();
    if (!board.sorted_on && sorted && board.held != 0) begin
      send_request(OP_CLEAR, 16'($urandom), 10'($urandom));
      settle();
    end
    // upper data bits are don't-care for the mode register
    mode_word = {10'($urandom), sorted};
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_SORTED_MODE;
    cfg_data_i <= mode_word;
    @(posedge clk_i);
    board.set_reg(REG_SORTED_MODE, mode_word);
    cfg_idx_i  <= REG_CAPACITY;
    cfg_data_i <= cap;
    @(posedge clk_i);
    board.set_reg(REG_CAPACITY, cap);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  task automatic send_random_request();
    op_e         op;
    logic [15:0] id;
    logic [9:0]  idx;
    int unsigned r, lim;
    r = $urandom_range(0, 99);
    if (r < 50)      op = OP_INSERT;
    else if (r < 70) op = OP_QUERY;
    else if (r < 96) op = OP_READ;
    else             op = OP_CLEAR;
    lim = (board.cap_reg > SET_DEPTH) ? SET_DEPTH : board.cap_reg;
    case ($urandom_range(0, 9))
      0:       id = 16'($urandom);
      1:       id = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      2:       id = 16'(lim + $urandom_range(0, 3));  // at or just past the bitmap edge
      default: begin
        if (board.sorted_on) id = pool_base + 16'($urandom_range(0, 47));
        else if (lim == 0)   id = '0;
        else                 id = 16'($urandom_range(0, lim - 1));
      end
    endcase
    case ($urandom_range(0, 7))
      0:       idx = 10'($urandom);
      1:       idx = 10'd1023;
      default: idx = 10'($urandom_range(0, (board.held > 1022) ? 1023 : board.held + 1));
    endcase
    send_request(op, id, idx);
  endtask

  initial begin
    bit          sorted;
    logic [10:0] cap;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings are bitmap mode, capacity 1024
    send_request(OP_READ,   16'd0,     10'd0);     // read on empty set
    send_request(OP_INSERT, 16'd0,     10'd0);
    send_request(OP_INSERT, 16'd1023,  10'd0);     // top of the bitmap domain
    send_request(OP_INSERT, 16'd1024,  10'd0);     // just out of range
    send_request(OP_INSERT, 16'hFFFF,  10'd0);
    send_request(OP_INSERT, 16'd0,     10'd0);     // duplicate
    send_request(OP_QUERY,  16'd1023,  10'd0);
    send_request(OP_QUERY,  16'hFFFF,  10'd0);     // out-of-range query
    send_request(OP_READ,   16'hFFFF,  10'd1);
    send_request(OP_READ,   16'd0,     10'd1023);  // index past count
    send_request(OP_CLEAR,  16'hFFFF,  10'h3FF);
    // full in bitmap mode: count already at capacity from ids above it
    enter_settings(1'b0, 11'd8);
    send_request(OP_INSERT, 16'd5,     10'd0);
    send_request(OP_INSERT, 16'd6,     10'd0);
    enter_settings(1'b0, 11'd2);
    send_request(OP_INSERT, 16'd0,     10'd0);     // full
    send_request(OP_INSERT, 16'd6,     10'd0);     // range check wins
    send_request(OP_QUERY,  16'd5,     10'd0);
    enter_settings(1'b0, 11'd0);
    send_request(OP_QUERY,  16'd0,     10'd0);     // zero capacity rejects all
    send_request(OP_CLEAR,  16'd0,     10'd0);
    enter_settings(1'b1, 11'd0);
    send_request(OP_INSERT, 16'd7,     10'd0);     // sorted, zero capacity: full
    enter_settings(1'b1, 11'd2047);                // saturates to 1024
    send_request(OP_INSERT, 16'hFFFF,  10'd0);
    send_request(OP_INSERT, 16'd0,     10'd0);
    send_request(OP_INSERT, 16'd300,   10'd0);     // lands between the two
    send_request(OP_INSERT, 16'd300,   10'd0);
    send_request(OP_QUERY,  16'd1,     10'd0);
    send_request(OP_READ,   16'd0,     10'd2);
    send_request(OP_CLEAR,  16'd0,     10'd0);

    // Random phases with fresh settings; the set is carried across phases
    for (int ph = 0; ph < 10; ph++) begin
      sorted = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0:       cap = 11'd0;
        1:       cap = 11'd1;
        2:       cap = 11'd1024;
        3:       cap = 11'd2047;
        4:       cap = 11'($urandom_range(1025, 2047));
        5:       cap = 11'($urandom);
        default: cap = 11'($urandom_range(2, 40));
      endcase
      enter_settings(sorted, cap);
      pool_base    = 16'($urandom);
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      repeat (25) send_random_request();
    end

    // Fill an empty sorted set to capacity back to back, then run it full
    enter_settings(1'b1, 11'(FILL_N));
    send_request(OP_CLEAR, 16'd0, 10'd0);
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    while (board.held < FILL_N) send_request(OP_INSERT, 16'($urandom), 10'($urandom));
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    repeat (6) send_request(OP_INSERT, 16'($urandom), 10'd0);
    repeat (4) send_request(OP_INSERT, board.arrival_ids[$urandom_range(0, FILL_N - 1)],
                            10'd0);
    repeat (4) send_request(OP_QUERY, 16'($urandom), 10'd0);
    send_request(OP_READ,  16'd0, 10'(FILL_N - 1));
    send_request(OP_READ,  16'd0, 10'd0);
    send_request(OP_CLEAR, 16'd0, 10'd0);
    send_request(OP_READ,  16'd0, 10'd0);

    settle();
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Requests: %0d insert, %0d query, %0d clear, %0d read over %0d settings",
             op_tally[OP_INSERT], op_tally[OP_QUERY], op_tally[OP_CLEAR],
             op_tally[OP_READ], settings_used);
    $display("Results checked %0d: %0d added, %0d present, %0d full, %0d rejected",
             board.checked_count, board.n_added, board.n_present, board.n_full,
             board.n_rejected);
    if (board.bad_count == 0 && board.owed_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results still owed", board.bad_count,
               board.owed_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
